/* rtl/lmu_pkg.sv */
package lmu_pkg;

    // fixed field widths
    localparam int PIX_W = 17;
    localparam int MAG_W = 7;

    // command queue between front and back, depth is a power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    // register indexes on the configuration port
    localparam logic REG_MAG_FACTOR     = 1'b0;
    localparam logic REG_INTERPOLATE_ON = 1'b1;

    // configuration seen by the front
    typedef struct packed {
        logic [MAG_W-1:0] mag_factor;
        logic             interpolate_on;
    } t_cfg;

    // one queued command: a run of results for the back to produce
    typedef struct packed {
        logic                    interp;
        logic signed [PIX_W-1:0] prev;
        logic signed [PIX_W-1:0] cur;
        logic [MAG_W-1:0]        mag;
    } t_cmd;

endpackage

/* rtl/lmu_front.sv */
module lmu_front #(
    parameter int MAX_MAG = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lmu_pkg::t_cfg                    i_cfg,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [lmu_pkg::PIX_W-1:0] i_pixel,
    input  logic                             i_row_end,
    input  logic                             i_q_full,
    output logic                             o_push,
    output lmu_pkg::t_cmd                    o_cmd
);

    logic signed [lmu_pkg::PIX_W-1:0] r_prev, n_prev;
    logic                             r_have, n_have;
    logic [lmu_pkg::MAG_W-1:0]        w_mag;
    logic                             w_accept;

    // clamp the factor to its working range
    always_comb begin
        if (i_cfg.mag_factor == '0) begin
            w_mag = lmu_pkg::MAG_W'(1);
        end else if (i_cfg.mag_factor > lmu_pkg::MAG_W'(MAX_MAG)) begin
            w_mag = lmu_pkg::MAG_W'(MAX_MAG);
        end else begin
            w_mag = i_cfg.mag_factor;
        end
    end

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;

    // classify the transaction and update the stored pixel
    always_comb begin
        n_prev       = r_prev;
        n_have       = r_have;
        o_push       = 1'b0;
        o_cmd.interp = i_cfg.interpolate_on;
        o_cmd.prev   = r_prev;
        o_cmd.cur    = i_pixel;
        o_cmd.mag    = w_mag;
        if (w_accept) begin
            n_prev = i_pixel;
            if (!i_cfg.interpolate_on) begin
                o_push = 1'b1;
                n_have = 1'b0;
            end else begin
                o_push = r_have;
                n_have = !i_row_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_have <= 1'b0;
        end else begin
            r_prev <= n_prev;
            r_have <= n_have;
        end
    end

endmodule

/* rtl/lmu_queue.sv */
module lmu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lmu_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output lmu_pkg::t_cmd o_data
);

    lmu_pkg::t_cmd               r_mem [lmu_pkg::Q_DEPTH];
    logic [lmu_pkg::Q_AW-1:0]    r_wptr, n_wptr;
    logic [lmu_pkg::Q_AW-1:0]    r_rptr, n_rptr;
    logic [lmu_pkg::Q_AW:0]      r_count, n_count;
    logic                        w_push, w_pop;

    assign o_full  = (r_count == (lmu_pkg::Q_AW + 1)'(lmu_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // pointer and fill count
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

/* rtl/lmu_back.sv */
module lmu_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  lmu_pkg::t_cmd                    i_q_data,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [lmu_pkg::PIX_W-1:0] o_pixel,
    output logic                             o_last
);

    localparam int DW = lmu_pkg::PIX_W + FRAC_BITS;
    localparam int AW = lmu_pkg::PIX_W + FRAC_BITS + 2;
    localparam int CW = $clog2(DW + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state                           r_state, n_state;
    logic signed [AW-1:0]             r_acc, n_acc;
    logic signed [AW-1:0]             r_step, n_step;
    logic [lmu_pkg::MAG_W-1:0]        r_cnt, n_cnt;
    logic [lmu_pkg::MAG_W-1:0]        r_div, n_div;
    logic [lmu_pkg::MAG_W-1:0]        r_rem, n_rem;
    logic [DW-1:0]                    r_dvd, n_dvd;
    logic [CW-1:0]                    r_bits, n_bits;
    logic                             r_neg, n_neg;
    logic                             r_ov, n_ov;
    logic signed [lmu_pkg::PIX_W-1:0] r_pix, n_pix;
    logic                             r_last, n_last;

    logic signed [lmu_pkg::PIX_W:0]   w_diff;
    logic [lmu_pkg::PIX_W:0]          w_absd;
    logic [lmu_pkg::MAG_W:0]          w_trial;
    logic                             w_ge;
    logic [DW-1:0]                    w_quo;
    logic signed [AW-1:0]             w_sh;
    logic signed [AW-1:0]             w_trunc;
    logic                             w_rnd;

    assign o_valid = r_ov;
    assign o_pixel = r_pix;
    assign o_last  = r_last;
    assign o_pop   = (r_state == ST_IDLE) && i_q_valid;

    // difference and its magnitude for the divider
    assign w_diff = {i_q_data.cur[lmu_pkg::PIX_W-1], i_q_data.cur}
                  - {i_q_data.prev[lmu_pkg::PIX_W-1], i_q_data.prev};
    assign w_absd = w_diff[lmu_pkg::PIX_W] ? (lmu_pkg::PIX_W + 1)'(-w_diff)
                                           : (lmu_pkg::PIX_W + 1)'(w_diff);

    // one restoring divide step
    assign w_trial = {r_rem, r_dvd[DW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_quo   = {r_dvd[DW-2:0], w_ge};

    // accumulator to pixel, truncated toward zero
    assign w_sh    = r_acc >>> FRAC_BITS;
    assign w_rnd   = r_acc[AW-1] && (r_acc[FRAC_BITS-1:0] != '0);
    assign w_trunc = w_sh + AW'(w_rnd);

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_div   = r_div;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_bits  = r_bits;
        n_neg   = r_neg;
        n_ov    = r_ov;
        n_pix   = r_pix;
        n_last  = r_last;

        // output register drains when taken
        if (!i_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_cnt = i_q_data.mag;
                    n_div = i_q_data.mag;
                    if (i_q_data.interp) begin
                        n_acc   = {{(AW - lmu_pkg::PIX_W){i_q_data.prev[lmu_pkg::PIX_W-1]}},
                                   i_q_data.prev} <<< FRAC_BITS;
                        n_neg   = w_diff[lmu_pkg::PIX_W];
                        n_dvd   = {w_absd[lmu_pkg::PIX_W-1:0], FRAC_BITS'(0)};
                        n_rem   = '0;
                        n_bits  = CW'(DW);
                        n_state = ST_DIV;
                    end else begin
                        n_acc   = {{(AW - lmu_pkg::PIX_W){i_q_data.cur[lmu_pkg::PIX_W-1]}},
                                   i_q_data.cur} <<< FRAC_BITS;
                        n_step  = '0;
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_DIV: begin
                n_rem  = w_ge ? lmu_pkg::MAG_W'(w_trial - {1'b0, r_div})
                              : lmu_pkg::MAG_W'(w_trial);
                n_dvd  = w_quo;
                n_bits = r_bits - 1'b1;
                if (r_bits == CW'(1)) begin
                    n_step  = r_neg ? -$signed(AW'(w_quo)) : $signed(AW'(w_quo));
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_ov || !i_stall) begin
                    n_ov   = 1'b1;
                    n_pix  = w_trunc[lmu_pkg::PIX_W-1:0];
                    n_last = (r_cnt == lmu_pkg::MAG_W'(1));
                    n_acc  = r_acc + r_step;
                    n_cnt  = r_cnt - 1'b1;
                    if (r_cnt == lmu_pkg::MAG_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_step <= n_step;
        r_cnt  <= n_cnt;
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_bits <= n_bits;
        r_neg  <= n_neg;
        r_pix  <= n_pix;
        r_last <= n_last;
    end

endmodule

/* rtl/line_magnify_upsampler_core.sv */
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_stall    i_pixel_in, i_row_end
// output    out        o_out_valid / i_out_stall  o_pixel_out, o_run_last
// config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// replication: dispatch, then mag_factor results, one per cycle while i_out_stall is low
// interpolation: dispatch, then a step from the bit-serial restoring
//   divider, then mag_factor results, one per cycle while i_out_stall is low
// mag_factor is taken as 1 when zero and as MAX_MAG above it
// a transaction that only stores its pixel pushes no command from the front
// reset is synchronous, active low; o_in_stall rises while the two-entry
//   command queue is full, and i_out_stall holds the output register and the emit step
module line_magnify_upsampler_core #(
    parameter int MAX_MAG   = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [lmu_pkg::PIX_W-1:0] i_pixel_in,
    input  logic                             i_row_end,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [lmu_pkg::PIX_W-1:0] o_pixel_out,
    output logic                             o_run_last,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [lmu_pkg::MAG_W-1:0] r_mag, n_mag;
    logic                      r_interp, n_interp;
    logic                      w_wr;
    lmu_pkg::t_cfg             w_cfg;
    lmu_pkg::t_cmd             w_push_cmd, w_q_cmd;
    logic                      w_push, w_full, w_pop, w_q_valid;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // register writes
    always_comb begin
        n_mag    = r_mag;
        n_interp = r_interp;
        if (w_wr) begin
            case (paddr[2])
                lmu_pkg::REG_MAG_FACTOR:     n_mag    = pwdata[lmu_pkg::MAG_W-1:0];
                lmu_pkg::REG_INTERPOLATE_ON: n_interp = pwdata[0];
                default: begin
                    n_mag = r_mag;
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        case (paddr[2])
            lmu_pkg::REG_MAG_FACTOR:     prdata = {(32 - lmu_pkg::MAG_W)'(0), r_mag};
            lmu_pkg::REG_INTERPOLATE_ON: prdata = {31'd0, r_interp};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag    <= lmu_pkg::MAG_W'(1);
            r_interp <= 1'b0;
        end else begin
            r_mag    <= n_mag;
            r_interp <= n_interp;
        end
    end

    assign w_cfg.mag_factor     = r_mag;
    assign w_cfg.interpolate_on = r_interp;

    lmu_front #(
        .MAX_MAG (MAX_MAG)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_pixel   (i_pixel_in),
        .i_row_end (i_row_end),
        .i_q_full  (w_full),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    lmu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_cmd)
    );

    lmu_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_cmd),
        .o_pop     (w_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_pixel   (o_pixel_out),
        .o_last    (o_run_last)
    );

endmodule
